### rtl/brb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared sizes, command codes and interface structs of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH  = 1024;                 // store slots
    localparam int AW     = $clog2(DEPTH);        // store address width
    localparam int CW     = $clog2(DEPTH + 1);    // count width (holds DEPTH)
    localparam int CFG_W  = 11;                   // capacity register width
    localparam int DW     = 8;                    // byte width
    localparam int WW     = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_PUTBACK = 2'd2,
        CMD_STATUS  = 2'd3
    } t_cmd;

    // store access issued by the controller
    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [DW-1:0] wdata;
    } t_mem_req;

    // registered result, data byte joined later from the store output
    typedef struct packed {
        logic             valid;
        logic             rd_ok;
        logic             error;
        logic [CFG_W-1:0] fill;
        logic [CFG_W-1:0] free;
        logic             empty;
    } t_rsp;

endpackage : brb_pkg
`default_nettype wire

### rtl/brb_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brb_store
// Byte store: one synchronous port, write or read, registered read data.
// ----------------------------------------------------------------------------
module brb_store (
    input  wire logic                  i_clk,
    input  wire brb_pkg::t_mem_req     i_req,
    output logic [brb_pkg::DW-1:0]     o_rdata
);

    logic [brb_pkg::DW-1:0] r_mem [brb_pkg::DEPTH];
    logic [brb_pkg::DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule : brb_store
`default_nettype wire

### rtl/brb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl
// Head and fill count of the ring, capacity register, store access and
// registered status of each item.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [1:0]                i_command,
    input  wire logic [brb_pkg::DW-1:0]    i_data_in,
    input  wire logic                      i_cfg_we,
    input  wire logic [brb_pkg::CFG_W-1:0] i_cfg_wdata,
    output brb_pkg::t_mem_req              o_req,
    output brb_pkg::t_rsp                  o_rsp
);

    logic [brb_pkg::CW-1:0] r_cap, n_cap;     // effective capacity, 1..DEPTH
    logic [brb_pkg::AW-1:0] r_head, n_head;
    logic [brb_pkg::CW-1:0] r_held, n_held;
    brb_pkg::t_rsp          r_rsp, n_rsp;

    logic                   full;
    logic                   err;
    logic                   rd_ok;
    logic [brb_pkg::CW:0]   tail_sum;
    logic [brb_pkg::CW:0]   tail_wrap;
    logic [brb_pkg::CW-1:0] head_inc;
    logic [brb_pkg::WW-1:0] cfg_ext;
    brb_pkg::t_cmd          cmd;

    assign cmd  = brb_pkg::t_cmd'(i_command);
    assign full = (r_held >= r_cap);

    // capacity clamp: zero acts as one, above DEPTH acts as DEPTH
    assign cfg_ext = brb_pkg::WW'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == '0) begin
            n_cap = brb_pkg::CW'(1);
        end else if (cfg_ext > brb_pkg::WW'(brb_pkg::DEPTH)) begin
            n_cap = brb_pkg::CW'(brb_pkg::DEPTH);
        end else begin
            n_cap = cfg_ext[brb_pkg::CW-1:0];
        end
    end

    // tail position, head + held stays below twice the capacity
    assign tail_sum  = {1'b0, brb_pkg::CW'(r_head)} + {1'b0, r_held};
    assign tail_wrap = (tail_sum >= {1'b0, r_cap}) ? (tail_sum - {1'b0, r_cap}) : tail_sum;
    assign head_inc  = brb_pkg::CW'(r_head) + brb_pkg::CW'(1);

    always_comb begin
        n_head      = r_head;
        n_held      = r_held;
        err         = 1'b0;
        rd_ok       = 1'b0;
        o_req.we    = 1'b0;
        o_req.addr  = r_head;
        o_req.wdata = i_data_in;
        case (cmd)
            brb_pkg::CMD_WRITE: begin
                o_req.addr = tail_wrap[brb_pkg::AW-1:0];
                if (full) begin
                    err = 1'b1;
                end else begin
                    o_req.we = i_accept;
                    n_held   = r_held + brb_pkg::CW'(1);
                end
            end
            brb_pkg::CMD_READ: begin
                if (r_held == '0) begin
                    err = 1'b1;
                end else begin
                    rd_ok  = 1'b1;
                    n_head = (head_inc == r_cap) ? '0 : head_inc[brb_pkg::AW-1:0];
                    n_held = r_held - brb_pkg::CW'(1);
                end
            end
            brb_pkg::CMD_PUTBACK: begin
                if (full) begin
                    err = 1'b1;
                end else begin
                    n_head     = (r_head == '0) ? brb_pkg::AW'(r_cap - brb_pkg::CW'(1))
                                                : r_head - brb_pkg::AW'(1);
                    o_req.addr = n_head;
                    o_req.we   = i_accept;
                    n_held     = r_held + brb_pkg::CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_rsp.valid = i_accept;
        n_rsp.rd_ok = rd_ok;
        n_rsp.error = err;
        n_rsp.fill  = brb_pkg::CFG_W'(n_held);
        n_rsp.free  = brb_pkg::CFG_W'(r_cap - n_held);
        n_rsp.empty = (n_held == '0);
    end

    // status fields need no reset, only the strobe does
    always_ff @(posedge i_clk) begin
        r_rsp.rd_ok <= n_rsp.rd_ok;
        r_rsp.error <= n_rsp.error;
        r_rsp.fill  <= n_rsp.fill;
        r_rsp.free  <= n_rsp.free;
        r_rsp.empty <= n_rsp.empty;
        if (!i_rst_n) begin
            r_cap       <= brb_pkg::CW'(brb_pkg::DEPTH);
            r_head      <= '0;
            r_held      <= '0;
            r_rsp.valid <= 1'b0;
        end else begin
            r_rsp.valid <= n_rsp.valid;
            if (i_cfg_we) begin
                r_cap  <= n_cap;
                r_head <= '0;
                r_held <= '0;
            end else if (i_accept) begin
                r_head <= n_head;
                r_held <= n_held;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule : brb_ctrl
`default_nettype wire

### rtl/byte_ring_buffer_with_putback.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_putback
// Circular byte queue with write, read, putback (unget) and status commands.
// ----------------------------------------------------------------------------
// Usage: one item (command + byte) is taken at every rising edge where start
// is high and busy is low; busy never rises, so an item may be issued every
// cycle. Each item yields exactly one result in the next cycle, shown for one
// cycle with o_valid high; the receiver cannot stall, so it must take every
// result as it comes. Status and byte are registered, the byte in the read port
// of the single-port byte store; head and fill count update at the accept
// edge, so the next item sees them at once. Writing i_cfg_wdata with
// i_cfg_we sets the capacity (zero acts as one, above the store depth acts
// as the depth) and empties the queue; store contents are kept. Write or
// putback when full, and read when empty, are refused with o_error set and
// leave the queue unchanged. o_data_out is zero except for a good read.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_putback (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_command,
    input  wire logic [brb_pkg::DW-1:0]    i_data_in,
    input  wire logic                      i_cfg_we,
    input  wire logic [brb_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                           o_valid,
    output logic [brb_pkg::DW-1:0]         o_data_out,
    output logic                           o_error,
    output logic [brb_pkg::CFG_W-1:0]      o_fill_count,
    output logic [brb_pkg::CFG_W-1:0]      o_free_space,
    output logic                           o_queue_empty
);

    brb_pkg::t_mem_req      mem_req;
    brb_pkg::t_rsp          rsp;
    logic [brb_pkg::DW-1:0] mem_rdata;
    logic                   accept;

    // the store never stalls an access; no interlock needed
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    brb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_data_in   (i_data_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_req       (mem_req),
        .o_rsp       (rsp)
    );

    // a written byte is visible to every read issued after the write
    brb_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // read byte arrives from the store alongside the registered status
    assign o_valid       = rsp.valid;
    assign o_data_out    = rsp.rd_ok ? mem_rdata : '0;
    assign o_error       = rsp.error;
    assign o_fill_count  = rsp.fill;
    assign o_free_space  = rsp.free;
    assign o_queue_empty = rsp.empty;

endmodule : byte_ring_buffer_with_putback
`default_nettype wire
